// File: design/ifd_pkg.sv
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants for the impedance-from-DFT block: field widths,
// result codes and the arctangent table of the phase rotator.
// ----------------------------------------------------------------------------
package ifd_pkg;

  // Field widths fixed by the sample and result formats
  localparam int SMP_W   = 16;  // one DFT word
  localparam int CH_W    = 4;   // channel index
  localparam int SUM_W   = 20;  // sum of up to 16 samples
  localparam int SQ_W    = 40;  // re^2 + im^2 of the sums
  localparam int RAD_W   = 44;  // 16 * sq, padded to an even width
  localparam int ROOT_W  = 22;  // isqrt of the radicand
  localparam int RES_W   = 24;  // calibration resistor
  localparam int CALM_W  = 18;  // Q17.1 magnitude
  localparam int MAG_W   = 16;
  localparam int IMP_W   = 32;
  localparam int PH_W    = 15;
  localparam int NUM_W   = 42;  // resistor * calibrated magnitude
  localparam int QUO_W   = 43;  // divider dividend / quotient
  localparam int DVS_W   = 22;  // divider divisor
  localparam int CX_W    = 32;  // rotator x and y
  localparam int CZ_W    = 24;  // rotator angle accumulator
  localparam int CORDIC_N = 16;

  localparam logic signed [PH_W-1:0] PHASE_LIMIT = 15'sd12868;
  localparam logic [RES_W-1:0] RES_DEFAULT = 24'd1000;

  // Configuration register indexes
  localparam logic REG_CALIB_RES = 1'b0;

  typedef enum logic {
    KIND_CAL  = 1'b0,
    KIND_MEAS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNCAL = 2'd1,
    ST_ZERO  = 2'd2
  } status_t;

  // atan(2^-k) * 2^20, rounded
  function automatic logic signed [CZ_W-1:0] atan_entry(input logic [3:0] k);
    logic signed [CZ_W-1:0] a;
    case (k)
      4'd0:  a = 24'sd823550;
      4'd1:  a = 24'sd486170;
      4'd2:  a = 24'sd256879;
      4'd3:  a = 24'sd130396;
      4'd4:  a = 24'sd65451;
      4'd5:  a = 24'sd32757;
      4'd6:  a = 24'sd16383;
      4'd7:  a = 24'sd8192;
      4'd8:  a = 24'sd4096;
      4'd9:  a = 24'sd2048;
      4'd10: a = 24'sd1024;
      4'd11: a = 24'sd512;
      4'd12: a = 24'sd256;
      4'd13: a = 24'sd128;
      4'd14: a = 24'sd64;
      4'd15: a = 24'sd32;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: design/ifd_div.sv
// ----------------------------------------------------------------------------
// ifd_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse
// loads the operands; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module ifd_div #(
  parameter int QW = 43,
  parameter int DW = 22
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [QW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] quo;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   rem_sh;
  logic [DW:0]   dvs_ext;
  logic [DW:0]   diff;
  logic          ge;

  // Trial subtract of the shifted remainder
  assign rem_sh  = {rem, quo[QW-1]};
  assign dvs_ext = {1'b0, divisor};
  assign ge      = (rem_sh >= dvs_ext);
  assign diff    = rem_sh - dvs_ext;
  assign quotient = quo;

  // Shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        quo <= {quo[QW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/impedance_from_dft_samples.sv
// ----------------------------------------------------------------------------
// impedance_from_dft_samples
// Sums DFT samples per point, forms the mean magnitude, stores it as the
// calibration reference or turns it into impedance and phase.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | beats
//  s_*      | in  | tuser kind, tdata channel/real/imag      | one per sample
//  m_*      | out | tuser kind, tdata chan/mag/imp/phase/st  | one per point
//  apb      | in  | calib_resistance at address 0            | setup/access write
//
// A sample that does not complete a point is added to the sums and s_tready
// stays high. The last sample of a point starts the work: two squares, a
// 22-step square root and two reciprocal multiplies for the means; for a
// measurement then 16 rotator steps, one multiply and a divide.
// s_tready stays low meanwhile. A finished result waits in the output
// register; a stall there holds the block before the next point.
// Reset (synchronous) clears sums, count and calibration and sets the
// resistor to 1000 ohms.
// ----------------------------------------------------------------------------
module impedance_from_dft_samples #(
  parameter int SAMPLES_PER_POINT = 5,
  parameter int MAX_CHANNELS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // channel[3:0], real_part[19:4], imag_part[35:20]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // result_channel[3:0], magnitude[19:4],
                                 // impedance_ohms[51:20], phase[66:52], status[68:67]
  output logic        m_tuser,   // result_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import ifd_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_POINT + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_POINT - 1);
  localparam logic [6:0] CH_LIMIT = 7'(MAX_CHANNELS);
  // Reciprocal of the point length: floor(x / N) = (x * RCP_N) >> RCP_SH
  localparam int RCP_SH = 26;
  localparam logic [27:0] RCP_N = 28'(((64'd1 << RCP_SH) + 64'(SAMPLES_PER_POINT)
                                       - 64'd1) / 64'(SAMPLES_PER_POINT));

  typedef enum logic [3:0] {
    S_IDLE, S_SQ_RE, S_SQ_IM, S_ROOT, S_MAG, S_QMAG,
    S_CORDIC, S_PHASE, S_IMP_MUL, S_IMP_GO, S_IMP_WAIT, S_FIN
  } state_t;

  state_t state;

  // Configuration and persistent state
  logic [RES_W-1:0]  calib_res;
  logic [CALM_W-1:0] cal_mag;
  logic              cal_valid;
  logic [CNT_W-1:0]  count;
  logic signed [SUM_W-1:0] real_sum;
  logic signed [SUM_W-1:0] imag_sum;

  // Working registers for one point
  logic              pt_kind;
  logic [CH_W-1:0]   pt_ch;
  logic signed [SUM_W-1:0] pt_rs;
  logic signed [SUM_W-1:0] pt_is;
  logic [SQ_W-1:0]   sq;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W-1:0] root;
  logic [24:0]       rem;
  logic [4:0]        step;
  logic [ROOT_W-1:0] root_val;
  logic [CALM_W-1:0] q_mag;
  logic [NUM_W-1:0]  num;
  logic signed [CX_W-1:0] cx;
  logic signed [CX_W-1:0] cy;
  logic signed [CZ_W-1:0] cz;
  logic [MAG_W-1:0]  res_mag;
  logic [IMP_W-1:0]  res_imp;
  logic signed [PH_W-1:0] res_phase;
  status_t           res_status;

  // Output register
  logic              out_kind;
  logic [CH_W-1:0]   out_ch;
  logic [MAG_W-1:0]  out_mag;
  logic [IMP_W-1:0]  out_imp;
  logic signed [PH_W-1:0] out_phase;
  status_t           out_status;

  // Input fields
  logic [CH_W-1:0]   in_ch;
  logic signed [SMP_W-1:0] in_re;
  logic signed [SMP_W-1:0] in_im;
  logic              in_ch_ok;
  logic signed [SUM_W-1:0] re_acc;
  logic signed [SUM_W-1:0] im_acc;

  assign in_ch    = s_tdata[3:0];
  assign in_re    = s_tdata[19:4];
  assign in_im    = s_tdata[35:20];
  assign in_ch_ok = ({3'b000, in_ch} < CH_LIMIT);
  assign re_acc   = real_sum + SUM_W'(in_re);
  assign im_acc   = imag_sum + SUM_W'(in_im);

  assign s_tready = (state == S_IDLE);

  // APB: always ready, one register at addresses 0 to 3 (only paddr[2] decoded)
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_CALIB_RES);
  assign prdata = (paddr[2] == REG_CALIB_RES) ? {8'h00, calib_res} : 32'h0;

  // Shared multiplier: squares of the sums, reciprocal scaling of the root,
  // then resistor * reference
  logic signed [24:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [52:0] prod;

  always_comb begin
    case (state)
      S_SQ_RE: begin
        mul_a = 25'(pt_rs);
        mul_b = 28'(pt_rs);
      end
      S_SQ_IM: begin
        mul_a = 25'(pt_is);
        mul_b = 28'(pt_is);
      end
      S_MAG: begin
        mul_a = {4'b0000, root_val[ROOT_W-1:1]};
        mul_b = RCP_N;
      end
      S_QMAG: begin
        mul_a = {3'b000, root_val};
        mul_b = RCP_N;
      end
      default: begin
        mul_a = {1'b0, calib_res};
        mul_b = {10'b0, cal_mag};
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  logic [SQ_W-1:0] sq_sum;
  assign sq_sum = sq + prod[SQ_W-1:0];

  // Square root: two radicand bits per step
  logic [24:0] rem_sh;
  logic [24:0] trial;
  logic        root_ge;
  assign rem_sh  = {rem[22:0], rad[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign root_ge = (rem_sh >= trial);

  // Divider for the impedance ratio
  logic             div_start;
  logic [QUO_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;

  assign div_dividend = QUO_W'(num) + QUO_W'(q_mag[CALM_W-1:1]);
  assign div_divisor  = DVS_W'(q_mag);
  assign div_start    = (state == S_IMP_GO);

  ifd_div #(.QW(QUO_W), .DW(DVS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Round half up from the odd-multiple bound, then clamp
  logic [ROOT_W-1:0] rcp_quo;
  logic [22:0]       t_plus;
  logic [21:0]       half;
  logic [MAG_W-1:0]  mag_val;
  logic [CALM_W-1:0] q_val;
  assign rcp_quo = prod[RCP_SH +: ROOT_W];
  assign t_plus  = {1'b0, rcp_quo} + 23'd1;
  assign half    = t_plus[22:1];
  assign mag_val = (|half[21:16]) ? '1 : half[15:0];
  assign q_val   = (|half[21:18]) ? '1 : half[17:0];

  // Vectoring rotator step
  logic signed [CX_W-1:0] nx, ny;
  logic signed [CZ_W-1:0] nz;
  logic signed [CZ_W-1:0] atan_k;
  assign atan_k = atan_entry(step[3:0]);

  always_comb begin
    if (cy > 0) begin
      nx = cx + (cy >>> step[3:0]);
      ny = cy - (cx >>> step[3:0]);
      nz = cz + atan_k;
    end else begin
      nx = cx - (cy >>> step[3:0]);
      ny = cy + (cx >>> step[3:0]);
      nz = cz - atan_k;
    end
  end

  // Rotator start values and phase rounding
  logic [SUM_W-1:0]        is_abs;
  logic signed [SUM_W-1:0] y_sum;
  logic signed [CZ_W-1:0]  z_rnd;
  logic signed [PH_W-1:0]  ph_val;
  assign is_abs = pt_is[SUM_W-1] ? SUM_W'(-pt_is) : pt_is;
  assign y_sum  = pt_is[SUM_W-1] ? -pt_rs : pt_rs;
  assign z_rnd  = (cz + 24'sd64) >>> 7;

  always_comb begin
    if (pt_rs == '0) begin
      ph_val = '0;
    end else if (pt_is == '0) begin
      ph_val = (pt_rs > 0) ? PHASE_LIMIT : -PHASE_LIMIT;
    end else if (z_rnd > CZ_W'(PHASE_LIMIT)) begin
      ph_val = PHASE_LIMIT;
    end else if (z_rnd < -CZ_W'(PHASE_LIMIT)) begin
      ph_val = -PHASE_LIMIT;
    end else begin
      ph_val = z_rnd[PH_W-1:0];
    end
  end

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      count     <= '0;
      real_sum  <= '0;
      imag_sum  <= '0;
      cal_mag   <= '0;
      cal_valid <= 1'b0;
      calib_res <= RES_DEFAULT;
    end else begin
      if (cfg_wr) begin
        calib_res <= pwdata[RES_W-1:0];
      end
      // Drop a taken beat unless a new one replaces it
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && in_ch_ok) begin
            if (count == CNT_LAST) begin
              pt_rs    <= re_acc;
              pt_is    <= im_acc;
              pt_kind  <= s_tuser;
              pt_ch    <= in_ch;
              real_sum <= '0;
              imag_sum <= '0;
              count    <= '0;
              state    <= S_SQ_RE;
            end else begin
              real_sum <= re_acc;
              imag_sum <= im_acc;
              count    <= count + 1'b1;
            end
          end
        end
        S_SQ_RE: begin
          sq    <= prod[SQ_W-1:0];
          state <= S_SQ_IM;
        end
        S_SQ_IM: begin
          rad   <= {sq_sum, 4'b0000};
          root  <= '0;
          rem   <= '0;
          step  <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          rad  <= {rad[RAD_W-3:0], 2'b00};
          rem  <= root_ge ? (rem_sh - trial) : rem_sh;
          root <= {root[ROOT_W-2:0], root_ge};
          step <= step + 1'b1;
          if (step == 5'(ROOT_W - 1)) begin
            root_val <= {root[ROOT_W-2:0], root_ge};
            state    <= S_MAG;
          end
        end
        S_MAG: begin
          res_mag <= mag_val;
          state   <= S_QMAG;
        end
        S_QMAG: begin
          q_mag <= q_val;
          if (pt_kind == KIND_CAL) begin
            cal_mag    <= q_val;
            cal_valid  <= 1'b1;
            res_status <= (q_val == '0) ? ST_ZERO : ST_OK;
            res_imp    <= '0;
            res_phase  <= '0;
            state      <= S_FIN;
          end else begin
            cx    <= CX_W'(is_abs) <<< 8;
            cy    <= CX_W'(y_sum) <<< 8;
            cz    <= '0;
            step  <= '0;
            state <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          cx   <= nx;
          cy   <= ny;
          cz   <= nz;
          step <= step + 1'b1;
          if (step == 5'(CORDIC_N - 1)) begin
            state <= S_PHASE;
          end
        end
        S_PHASE: begin
          res_phase <= ph_val;
          if (!cal_valid) begin
            res_status <= ST_UNCAL;
            res_imp    <= '0;
            state      <= S_FIN;
          end else if (q_mag == '0) begin
            res_status <= ST_ZERO;
            res_imp    <= '1;
            state      <= S_FIN;
          end else begin
            state <= S_IMP_MUL;
          end
        end
        S_IMP_MUL: begin
          num   <= prod[NUM_W-1:0];
          state <= S_IMP_GO;
        end
        S_IMP_GO: begin
          state <= S_IMP_WAIT;
        end
        S_IMP_WAIT: begin
          if (div_done) begin
            res_imp    <= (|div_quo[QUO_W-1:IMP_W]) ? '1 : div_quo[IMP_W-1:0];
            res_status <= ST_OK;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_kind   <= pt_kind;
            out_ch     <= pt_ch;
            out_mag    <= res_mag;
            out_imp    <= res_imp;
            out_phase  <= res_phase;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {3'b000, out_status, out_phase, out_imp, out_mag, out_ch};

endmodule

// File: design/ifd_chk.sv
// ----------------------------------------------------------------------------
// ifd_chk
// Port-level checks on the impedance block, attached to the top level.
// ----------------------------------------------------------------------------
module ifd_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tuser
);

  import ifd_pkg::*;

  logic [1:0]  st;
  logic [31:0] imp;
  logic [14:0] ph;
  assign st  = m_tdata[68:67];
  assign imp = m_tdata[51:20];
  assign ph  = m_tdata[66:52];

  // No result straight out of reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Calibration result carries no impedance and no phase
  a_cal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_CAL) |-> (imp == '0) && (ph == '0)
      && (st != ST_UNCAL))
    else $error("calibration beat with impedance or phase");

  // Measurement status matches impedance
  a_meas: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_MEAS) |->
      ((st == ST_ZERO) && (imp == '1)) || ((st == ST_UNCAL) && (imp == '0))
      || (st == ST_OK))
    else $error("measurement status and impedance disagree");

endmodule

bind impedance_from_dft_samples ifd_chk u_ifd_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/sv/impedance_from_dft_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// impedance_from_dft_checker
// Watches the sample, result and register ports of the impedance block. It
// keeps its own copy of the point sums, the calibration and the resistor,
// predicts each finished point and compares it field by field with the
// result beats in order.
// ----------------------------------------------------------------------------
module impedance_from_dft_checker
  import ifd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // channel[3:0], real_part[19:4], imag_part[35:20]
  input  logic        s_tuser,   // kind
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // result_channel[3:0], magnitude[19:4],
                                 // impedance_ohms[51:20], phase[66:52], status[68:67]
  input  logic        m_tuser,   // result_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fails,
  output int          pending
);

  localparam int POINT_LEN = 5;

  typedef struct {
    kind_t       kind;
    logic [3:0]  chan;
    logic [15:0] mag;
    logic [31:0] imp;
    logic [14:0] phase;
    status_t     status;
  } point_result_t;

  // atan(2^-k) scaled by 2^20
  localparam longint ROT_ANGLE [16] = '{823550, 486170, 256879, 130396, 65451, 32757,
                                        16383, 8192, 4096, 2048, 1024, 512, 256, 128,
                                        64, 32};

  point_result_t  expected_points[$];
  logic [23:0]    resistance;
  int             points_samples;
  int             re_acc;
  int             im_acc;
  longint         cal_q;
  bit             calibrated;

  assign pending = expected_points.size();

  // Largest m <= lim with m == 0 or (2m-1)^2 * N^2 <= 4 * scale * sq
  function automatic longint unsigned rounded_root(longint unsigned sq,
                                                   longint unsigned scale,
                                                   longint unsigned lim);
    longint unsigned lo, hi, mid, t;
    lo = 0;
    hi = lim;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * POINT_LEN * POINT_LEN <= 4 * scale * sq) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Vectoring rotation of (|im|, +-re), angle rounded to 2^-13 rad
  function automatic logic [14:0] point_phase(longint re, longint im);
    longint x, y, z, nx, ny, p;
    if (re == 0) return '0;
    if (im == 0) return re > 0 ? PHASE_LIMIT : -PHASE_LIMIT;
    x = (im < 0 ? -im : im) * 256;
    y = (im < 0 ? -re : re) * 256;
    z = 0;
    for (int k = 0; k < 16; k++) begin
      if (y > 0) begin
        nx = x + (y >>> k);
        ny = y - (x >>> k);
        z += ROT_ANGLE[k];
      end else begin
        nx = x - (y >>> k);
        ny = y + (x >>> k);
        z -= ROT_ANGLE[k];
      end
      x = nx;
      y = ny;
    end
    p = (z + 64) >>> 7;
    if (p > 12868) p = 12868;
    if (p < -12868) p = -12868;
    return p[14:0];
  endfunction

  // Accumulate one sample, push a prediction when the point completes
  task automatic absorb_sample(kind_t kind, logic [3:0] chan,
                               logic signed [15:0] re, logic signed [15:0] im);
    point_result_t r;
    longint rs, is, q, num, imp;
    longint unsigned sq;
    re_acc += re;
    im_acc += im;
    points_samples++;
    if (points_samples < POINT_LEN) return;
    rs = re_acc;
    is = im_acc;
    points_samples = 0;
    re_acc = 0;
    im_acc = 0;
    sq = rs * rs + is * is;
    r.kind = kind;
    r.chan = chan;
    r.mag = 16'(rounded_root(sq, 1, 65535));
    q = longint'(rounded_root(sq, 4, 262143));
    r.imp = '0;
    r.phase = '0;
    r.status = ST_OK;
    if (kind == KIND_CAL) begin
      cal_q = q;
      calibrated = 1'b1;
      if (q == 0) r.status = ST_ZERO;
    end else begin
      r.phase = point_phase(rs, is);
      if (!calibrated) begin
        r.status = ST_UNCAL;
      end else if (q == 0) begin
        r.status = ST_ZERO;
        r.imp = '1;
      end else begin
        num = longint'(resistance) * cal_q;
        imp = (num + q / 2) / q;
        r.imp = imp > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : imp[31:0];
      end
    end
    expected_points.push_back(r);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    fails++;
  endtask

  // Follow register writes, sample beats and result beats
  always @(posedge clk) begin
    point_result_t r;
    if (rst) begin
      resistance <= RES_DEFAULT;
      points_samples = 0;
      re_acc = 0;
      im_acc = 0;
      cal_q = 0;
      calibrated = 1'b0;
      expected_points.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_CALIB_RES)
        resistance <= pwdata[23:0];
      if (s_tvalid && s_tready)
        absorb_sample(kind_t'(s_tuser), s_tdata[3:0], s_tdata[19:4], s_tdata[35:20]);
      if (m_tvalid && m_tready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: result beat with no point pending", $time);
          fails++;
        end else begin
          r = expected_points.pop_front();
          if (m_tuser != r.kind) report_mismatch("result_kind", m_tuser, r.kind);
          if (m_tdata[3:0] != r.chan) report_mismatch("result_channel", m_tdata[3:0], r.chan);
          if (m_tdata[19:4] != r.mag) report_mismatch("magnitude", m_tdata[19:4], r.mag);
          if (m_tdata[51:20] != r.imp) report_mismatch("impedance_ohms", m_tdata[51:20], r.imp);
          if (m_tdata[66:52] != r.phase) report_mismatch("phase", m_tdata[66:52], r.phase);
          if (m_tdata[68:67] != r.status) report_mismatch("status", m_tdata[68:67], r.status);
        end
      end
    end
  end

  initial fails = 0;

endmodule

// File: tb/sv/impedance_from_dft_samples_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// impedance_from_dft_samples_tb
// Drives DFT sample points, calibration and measurement, through the block
// with bursty input and a stalling result side, rewrites the calibration
// resistor between phases, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module impedance_from_dft_samples_tb;
  import ifd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // channel[3:0], real_part[19:4], imag_part[35:20]
  logic        s_tuser = 1'b0; // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // result_channel[3:0], magnitude[19:4],
                               // impedance_ohms[51:20], phase[66:52], status[68:67]
  logic        m_tuser;        // result_kind
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fails;
  int pending;
  int cycles = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;

  always #2 clk = ~clk;

  impedance_from_dft_samples i_dut (.*);
  impedance_from_dft_checker i_chk (.*);

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result side: long hold on request, else changing patterns
  initial begin
    int mode;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk);
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= $urandom_range(0, 7) != 0;
          default: m_tready <= $urandom_range(0, 7) == 0;
        endcase
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Hold until every point is out and the datapath has drained
  task automatic drain_points();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Offer one sample beat, then maybe a gap per the burst schedule
  task automatic send_sample(kind_t kind, logic [3:0] chan, logic [15:0] re, logic [15:0] im);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {4'b0, im, re, chan};
    do @(posedge clk); while (!s_tready);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_point(kind_t kind, logic [3:0] chan, logic [15:0] re, logic [15:0] im);
    repeat (5) send_sample(kind, chan, re, im);
  endtask

  function automatic logic [15:0] pick_word(int cls);
    case (cls)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 6)) - 3);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return '0;
    endcase
  endfunction

  // One random point: mostly clean, sometimes mixed kinds and channels
  task automatic random_point(kind_t kind);
    int rc, ic;
    bit mixed;
    logic [3:0] chan;
    rc = $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
    ic = $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
    mixed = $urandom_range(0, 9) == 0;
    chan = 4'($urandom_range(0, 15));
    for (int i = 0; i < 5; i++) begin
      if (mixed) send_sample(kind_t'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                             pick_word(rc), pick_word(ic));
      else send_sample(kind, chan, pick_word(rc), pick_word(ic));
    end
  endtask

  initial begin
    logic [31:0] res_values [8];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: uncalibrated, zero calibration, zero measurement, mixed extremes
    send_point(KIND_MEAS, 4'hF, 16'h7FFF, 16'h8000);
    send_point(KIND_CAL, 4'h0, 16'h0000, 16'h0000);
    send_point(KIND_MEAS, 4'h3, 16'd100, 16'h0000);
    send_point(KIND_MEAS, 4'h7, 16'h0000, 16'h0000);
    send_sample(KIND_MEAS, 4'h9, 16'h7FFF, 16'h7FFF);
    send_sample(KIND_CAL, 4'h2, 16'h8000, 16'h7FFF);
    send_sample(KIND_MEAS, 4'hC, 16'h0000, 16'h8000);
    send_sample(KIND_MEAS, 4'h5, 16'hFFFF, 16'h0001);
    send_sample(KIND_CAL, 4'hA, 16'h8000, 16'h8000);
    drain_points();
    reg_write(3'd4, 32'hFFFF_FFFF);

    // Random phases, each under its own resistor value
    res_values = '{32'd1, 32'h00FF_FFFF, 32'd0, 32'd1000, 32'h0,
                   32'h0, 32'h0, 32'hFF00_0001};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph >= 4 && ph < 7) res_values[ph] = $urandom;
      reg_write(3'd0, res_values[ph]);
      if (ph == 3) hold_request = 1'b1;
      random_point($urandom_range(0, 3) == 0 ? KIND_MEAS : KIND_CAL);
      for (int n = 0; n < 26; n++)
        random_point($urandom_range(0, 7) == 0 ? KIND_CAL : KIND_MEAS);
      if ($urandom_range(0, 2) == 0) send_sample(KIND_MEAS, 4'($urandom_range(0, 15)),
                                                 pick_word(0), pick_word(0));
      drain_points();
    end

    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ifd_pkg.sv
design/ifd_div.sv
design/impedance_from_dft_samples.sv
design/ifd_chk.sv
tb/sv/impedance_from_dft_checker.sv
tb/sv/impedance_from_dft_samples_tb.sv
